// ===== sv/eip_pkg.sv =====
// Shared types and constants for the Ethernet / IPv4 / TCP header parser.
package eip_pkg;

   // Default capture limit, in bytes per frame
   localparam int MAX_FRAME_BYTES_DEF = 2048;

   // Header byte positions, counted from the first destination MAC byte
   localparam int DST_START    = 0;
   localparam int SRC_START    = 6;
   localparam int TYPE_START   = 12;
   localparam int VERHL_START  = 14;
   localparam int TOTLEN_START = 16;
   localparam int IDENT_START  = 18;
   localparam int TTL_START    = 22;
   localparam int ADDR_START   = 26;

   // TCP header byte offsets from its start
   localparam int TCP_PORTS_OFS = 0;
   localparam int TCP_SEQ_OFS   = 4;
   localparam int TCP_FLAGS_OFS = 12;
   localparam int TCP_HDR_LEN   = 14;

   // TCP start position fits in 7 bits (14 + 15 * 4 = 74)
   localparam int TCP_START_W = 7;

   // Ethertype and protocol values
   localparam logic [15:0] TYPE_MIN  = 16'h0600;
   localparam logic [15:0] TYPE_IPV4 = 16'h0800;
   localparam logic [15:0] TYPE_ARP  = 16'h0806;
   localparam logic [15:0] TYPE_RARP = 16'h8035;
   localparam logic [7:0]  PROTO_TCP = 8'd6;

   // Frame class codes
   localparam logic [2:0] CLASS_LENGTH   = 3'd0;
   localparam logic [2:0] CLASS_OTHER    = 3'd1;
   localparam logic [2:0] CLASS_ARP      = 3'd2;
   localparam logic [2:0] CLASS_IPV4     = 3'd3;
   localparam logic [2:0] CLASS_IPV4_TCP = 3'd4;

   // One input item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } byte_item_type;

   // Raw header fields as captured, network byte order
   typedef struct packed {
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic [15:0] type_or_length;
      logic [7:0]  ip_version_hlen;
      logic [15:0] ip_total_length;
      logic [31:0] ip_ident_flags_offset;
      logic [15:0] ip_ttl_protocol;
      logic [63:0] ip_addresses;
      logic [31:0] tcp_ports;
      logic [63:0] tcp_seq_ack;
      logic [15:0] tcp_offset_flags;
   } hdr_fields_type;

   // Handshake between capture and result stage
   typedef struct packed {
      logic consume;   // capture takes the held item this cycle
      logic frame_end; // that item carries the last-byte mark
   } cap_ctrl_type;

endpackage

// ===== sv/eip_req_if.sv =====
// Input channel: one frame byte per item with a last-byte mark.
interface eip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== sv/eip_rsp_if.sv =====
// Result channel: one parsed header record per frame.
interface eip_rsp_if;
   logic        valid;
   logic        ready;
   logic [47:0] dst_mac;
   logic [47:0] src_mac;
   logic [15:0] type_or_length;
   logic [2:0]  frame_class;
   logic [7:0]  ip_version_hlen;
   logic [15:0] ip_total_length;
   logic [31:0] ip_ident_flags_offset;
   logic [15:0] ip_ttl_protocol;
   logic [63:0] ip_addresses;
   logic [31:0] tcp_ports;
   logic [63:0] tcp_seq_ack;
   logic [15:0] tcp_offset_flags;

   modport source (
      output valid, input ready,
      output dst_mac, output src_mac, output type_or_length, output frame_class,
      output ip_version_hlen, output ip_total_length, output ip_ident_flags_offset,
      output ip_ttl_protocol, output ip_addresses, output tcp_ports,
      output tcp_seq_ack, output tcp_offset_flags
   );
   modport sink (
      input valid, output ready,
      input dst_mac, input src_mac, input type_or_length, input frame_class,
      input ip_version_hlen, input ip_total_length, input ip_ident_flags_offset,
      input ip_ttl_protocol, input ip_addresses, input tcp_ports,
      input tcp_seq_ack, input tcp_offset_flags
   );
endinterface

// ===== sv/eth_ipv4_tcp_header_parser.sv =====
// Top level of the Ethernet / IPv4 / TCP header parser.
//
//  Channel  Dir  Carries                                   Item accepted when
//  req_ch   in   frame_byte, last_byte                     valid && ready
//  rsp_ch   out  MACs, type, class, IPv4 and TCP fields    valid && ready
//
// One byte per cycle sustained unless the input stalls as described below; a byte is
// accepted into an input register and taken by the capture logic from there. A
// frame's record is loaded into the result register at the edge where its last
// byte leaves the input register.
// Synchronous active-high reset clears the valid flags, byte counter, TCP start and fields.
// The input stalls only while a held last byte waits for an earlier record that
// is still in the result register; bytes behind it wait with it.
module eth_ipv4_tcp_header_parser #(
   parameter int MAX_FRAME_BYTES = eip_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   eip_req_if.sink  req_ch,
   eip_rsp_if.source rsp_ch
);
   import eip_pkg::*;

   logic           in_valid_ff, in_valid_in;
   byte_item_type  in_item_ff;
   cap_ctrl_type   ctrl;
   hdr_fields_type fields;
   logic           out_free;
   logic           req_take;

   // Held byte moves on unless it ends a frame and the result slot is busy
   assign ctrl.frame_end = in_item_ff.last_byte;
   assign ctrl.consume   = in_valid_ff && (!in_item_ff.last_byte || out_free);

   assign req_ch.ready = !in_valid_ff || ctrl.consume;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (ctrl.consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.frame_byte <= req_ch.frame_byte;
         in_item_ff.last_byte  <= req_ch.last_byte;
      end
   end

   eip_byte_capture #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_capture (
      .clock  (clock),
      .reset  (reset),
      .item   (in_item_ff),
      .ctrl   (ctrl),
      .fields (fields)
   );

   eip_result_stage u_result (
      .clock    (clock),
      .reset    (reset),
      .fields   (fields),
      .load     (ctrl.consume && ctrl.frame_end),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== sv/eip_byte_capture.sv =====
// Byte position counter, TCP start tracking and header field capture.
module eip_byte_capture #(
   parameter int MAX_FRAME_BYTES = eip_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  eip_pkg::byte_item_type item,
   input  eip_pkg::cap_ctrl_type  ctrl,
   output eip_pkg::hdr_fields_type fields
);
   import eip_pkg::*;

   localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

   logic [PW-1:0]          pos_ff, pos_in;
   logic [TCP_START_W-1:0] tcp_start_ff, tcp_start_in;
   hdr_fields_type         fields_ff, fields_in;
   hdr_fields_type         merged;
   logic                   take;
   logic [TCP_START_W-1:0] tcp_eff;
   logic [PW-1:0]          tcp_rel_wide;
   logic                   tcp_hit;
   logic [3:0]             tcp_rel;
   logic [7:0]             b;

   assign b    = item.frame_byte;
   assign take = (pos_ff < PW'(MAX_FRAME_BYTES));

   // TCP start: taken from the IHL nibble when byte 14 itself arrives
   always_comb begin
      if (pos_ff == PW'(VERHL_START)) begin
         tcp_eff = TCP_START_W'(VERHL_START) + {1'b0, b[3:0], 2'b00};
      end else begin
         tcp_eff = tcp_start_ff;
      end
      tcp_rel_wide = pos_ff - PW'(tcp_eff);
      // no TCP byte ahead of the IP header
      tcp_hit      = (pos_ff >= PW'(VERHL_START)) && (pos_ff >= PW'(tcp_eff)) &&
                     (tcp_rel_wide < PW'(TCP_HDR_LEN));
      tcp_rel      = tcp_rel_wide[3:0];
   end

   // Drop the byte into every lane whose position matches
   always_comb begin
      merged = fields_ff;
      if (take) begin
         for (int i = 0; i < 6; i++) begin
            if (pos_ff == PW'(DST_START + i)) merged.dst_mac[8*(5-i) +: 8] = b;
            if (pos_ff == PW'(SRC_START + i)) merged.src_mac[8*(5-i) +: 8] = b;
         end
         for (int i = 0; i < 2; i++) begin
            if (pos_ff == PW'(TYPE_START + i))   merged.type_or_length[8*(1-i) +: 8] = b;
            if (pos_ff == PW'(TOTLEN_START + i)) merged.ip_total_length[8*(1-i) +: 8] = b;
            if (pos_ff == PW'(TTL_START + i))    merged.ip_ttl_protocol[8*(1-i) +: 8] = b;
            if (tcp_hit && tcp_rel == 4'(TCP_FLAGS_OFS + i))
               merged.tcp_offset_flags[8*(1-i) +: 8] = b;
         end
         if (pos_ff == PW'(VERHL_START)) merged.ip_version_hlen = b;
         for (int i = 0; i < 4; i++) begin
            if (pos_ff == PW'(IDENT_START + i)) merged.ip_ident_flags_offset[8*(3-i) +: 8] = b;
            if (tcp_hit && tcp_rel == 4'(TCP_PORTS_OFS + i))
               merged.tcp_ports[8*(3-i) +: 8] = b;
         end
         for (int i = 0; i < 8; i++) begin
            if (pos_ff == PW'(ADDR_START + i)) merged.ip_addresses[8*(7-i) +: 8] = b;
            if (tcp_hit && tcp_rel == 4'(TCP_SEQ_OFS + i))
               merged.tcp_seq_ack[8*(7-i) +: 8] = b;
         end
      end
   end

   assign fields = merged;

   // Next state: clear after the frame's last byte, hold when nothing is taken
   always_comb begin
      pos_in       = pos_ff;
      tcp_start_in = tcp_start_ff;
      fields_in    = fields_ff;
      if (ctrl.consume) begin
         if (ctrl.frame_end) begin
            pos_in       = '0;
            tcp_start_in = '0;
            fields_in    = '0;
         end else if (take) begin
            pos_in       = pos_ff + PW'(1);
            tcp_start_in = tcp_eff;
            fields_in    = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tcp_start_ff <= '0;
         fields_ff    <= '0;
      end else begin
         pos_ff       <= pos_in;
         tcp_start_ff <= tcp_start_in;
         fields_ff    <= fields_in;
      end
   end

endmodule

// ===== sv/eip_result_stage.sv =====
// Frame classification, field masking and the result register.
module eip_result_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  eip_pkg::hdr_fields_type fields,
   input  logic                    load,
   output logic                    out_free,
   eip_rsp_if.source               rsp_ch
);
   import eip_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] cls;
   logic       is_ip;
   logic       is_tcp;

   logic [47:0] dst_mac_ff, src_mac_ff;
   logic [15:0] type_ff;
   logic [2:0]  class_ff;
   logic [7:0]  verhl_ff;
   logic [15:0] totlen_ff;
   logic [31:0] identfo_ff;
   logic [15:0] ttlproto_ff;
   logic [63:0] addrs_ff;
   logic [31:0] ports_ff;
   logic [63:0] seqack_ff;
   logic [15:0] offflags_ff;

   // Frame class from ethertype and IP protocol
   always_comb begin
      if (fields.type_or_length < TYPE_MIN) begin
         cls = CLASS_LENGTH;
      end else if (fields.type_or_length == TYPE_IPV4) begin
         cls = (fields.ip_ttl_protocol[7:0] == PROTO_TCP) ? CLASS_IPV4_TCP : CLASS_IPV4;
      end else if (fields.type_or_length == TYPE_ARP ||
                   fields.type_or_length == TYPE_RARP) begin
         cls = CLASS_ARP;
      end else begin
         cls = CLASS_OTHER;
      end
      is_ip  = (cls == CLASS_IPV4) || (cls == CLASS_IPV4_TCP);
      is_tcp = (cls == CLASS_IPV4_TCP);
   end

   // Output slot is free when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Record payload; IP and TCP fields zeroed where the class rules them out
   always_ff @(posedge clock) begin
      if (load) begin
         dst_mac_ff  <= fields.dst_mac;
         src_mac_ff  <= fields.src_mac;
         type_ff     <= fields.type_or_length;
         class_ff    <= cls;
         verhl_ff    <= is_ip  ? fields.ip_version_hlen       : '0;
         totlen_ff   <= is_ip  ? fields.ip_total_length       : '0;
         identfo_ff  <= is_ip  ? fields.ip_ident_flags_offset : '0;
         ttlproto_ff <= is_ip  ? fields.ip_ttl_protocol       : '0;
         addrs_ff    <= is_ip  ? fields.ip_addresses          : '0;
         ports_ff    <= is_tcp ? fields.tcp_ports             : '0;
         seqack_ff   <= is_tcp ? fields.tcp_seq_ack           : '0;
         offflags_ff <= is_tcp ? fields.tcp_offset_flags      : '0;
      end
   end

   assign rsp_ch.valid                 = rsp_valid_ff;
   assign rsp_ch.dst_mac               = dst_mac_ff;
   assign rsp_ch.src_mac               = src_mac_ff;
   assign rsp_ch.type_or_length        = type_ff;
   assign rsp_ch.frame_class           = class_ff;
   assign rsp_ch.ip_version_hlen       = verhl_ff;
   assign rsp_ch.ip_total_length       = totlen_ff;
   assign rsp_ch.ip_ident_flags_offset = identfo_ff;
   assign rsp_ch.ip_ttl_protocol       = ttlproto_ff;
   assign rsp_ch.ip_addresses          = addrs_ff;
   assign rsp_ch.tcp_ports             = ports_ff;
   assign rsp_ch.tcp_seq_ack           = seqack_ff;
   assign rsp_ch.tcp_offset_flags      = offflags_ff;

endmodule

// ===== test/header_record_checker.sv =====
// Checker for the header parser: predicts each parsed record and compares it.
`timescale 1ns / 100ps
module header_record_checker #(
   parameter int MAX_BYTES = eip_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic clock,
   input  logic reset,
   eip_req_if   req_ch,
   eip_rsp_if   rsp_ch,
   output int   mismatch_count,
   output int   records_pending
);
   import eip_pkg::*;

   // Deepest header byte that can matter: TCP header behind the longest IP header
   localparam int HDR_SPAN = VERHL_START + 15 * 4 + TCP_HDR_LEN;

   typedef struct packed {
      hdr_fields_type fields;
      logic [2:0]     frame_class;
   } header_record_type;

   // Header bytes of the frame in progress, zero past its end
   logic [7:0]        seen_bytes [HDR_SPAN];
   int                byte_count;
   header_record_type expected_headers [$];
   header_record_type oldest;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: parse mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic clear_frame();
      int i;
      for (i = 0; i < HDR_SPAN; i++)
         seen_bytes[i] = 8'h00;
      byte_count = 0;
   endtask

   // Big-endian value of len bytes starting at position start
   function automatic logic [63:0] wire_field(input int start, input int len);
      logic [63:0] acc;
      int i;
      acc = '0;
      for (i = 0; i < len; i++)
         acc = {acc[55:0], seen_bytes[start + i]};
      return acc;
   endfunction

   // Record for the frame just closed by its last byte
   function automatic header_record_type decode_header();
      header_record_type rec;
      logic [15:0] ethertype;
      logic [15:0] ttl_proto;
      int tcp_base;
      rec = '0;
      ethertype = 16'(wire_field(TYPE_START, 2));
      ttl_proto = 16'(wire_field(TTL_START, 2));
      tcp_base  = VERHL_START + 4 * int'(seen_bytes[VERHL_START][3:0]);

      if (ethertype < TYPE_MIN)
         rec.frame_class = CLASS_LENGTH;
      else if (ethertype == TYPE_IPV4)
         rec.frame_class = (ttl_proto[7:0] == PROTO_TCP) ? CLASS_IPV4_TCP : CLASS_IPV4;
      else if (ethertype == TYPE_ARP || ethertype == TYPE_RARP)
         rec.frame_class = CLASS_ARP;
      else
         rec.frame_class = CLASS_OTHER;

      rec.fields.dst_mac        = 48'(wire_field(DST_START, 6));
      rec.fields.src_mac        = 48'(wire_field(SRC_START, 6));
      rec.fields.type_or_length = ethertype;

      // IPv4 fields only for IPv4 frames
      if (rec.frame_class == CLASS_IPV4 || rec.frame_class == CLASS_IPV4_TCP) begin
         rec.fields.ip_version_hlen       = 8'(wire_field(VERHL_START, 1));
         rec.fields.ip_total_length       = 16'(wire_field(TOTLEN_START, 2));
         rec.fields.ip_ident_flags_offset = 32'(wire_field(IDENT_START, 4));
         rec.fields.ip_ttl_protocol       = ttl_proto;
         rec.fields.ip_addresses          = wire_field(ADDR_START, 8);
      end

      // TCP fields sit wherever the IHL puts them, even over the IP header
      if (rec.frame_class == CLASS_IPV4_TCP) begin
         rec.fields.tcp_ports        = 32'(wire_field(tcp_base + TCP_PORTS_OFS, 4));
         rec.fields.tcp_seq_ack      = wire_field(tcp_base + TCP_SEQ_OFS, 8);
         rec.fields.tcp_offset_flags = 16'(wire_field(tcp_base + TCP_FLAGS_OFS, 2));
      end
      return rec;
   endfunction

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic compare_record(input header_record_type want);
      check_field("dst_mac", 64'(rsp_ch.dst_mac), 64'(want.fields.dst_mac));
      check_field("src_mac", 64'(rsp_ch.src_mac), 64'(want.fields.src_mac));
      check_field("type_or_length", 64'(rsp_ch.type_or_length),
                  64'(want.fields.type_or_length));
      check_field("frame_class", 64'(rsp_ch.frame_class), 64'(want.frame_class));
      check_field("ip_version_hlen", 64'(rsp_ch.ip_version_hlen),
                  64'(want.fields.ip_version_hlen));
      check_field("ip_total_length", 64'(rsp_ch.ip_total_length),
                  64'(want.fields.ip_total_length));
      check_field("ip_ident_flags_offset", 64'(rsp_ch.ip_ident_flags_offset),
                  64'(want.fields.ip_ident_flags_offset));
      check_field("ip_ttl_protocol", 64'(rsp_ch.ip_ttl_protocol),
                  64'(want.fields.ip_ttl_protocol));
      check_field("ip_addresses", rsp_ch.ip_addresses, want.fields.ip_addresses);
      check_field("tcp_ports", 64'(rsp_ch.tcp_ports), 64'(want.fields.tcp_ports));
      check_field("tcp_seq_ack", rsp_ch.tcp_seq_ack, want.fields.tcp_seq_ack);
      check_field("tcp_offset_flags", 64'(rsp_ch.tcp_offset_flags),
                  64'(want.fields.tcp_offset_flags));
   endtask

   // Results are checked before the same edge's input is taken
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         expected_headers.delete();
         mismatch_count  = 0;
         records_pending <= 0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_headers.size() == 0) begin
               report_mismatch("record with no frame outstanding");
            end else begin
               oldest = expected_headers.pop_front();
               compare_record(oldest);
            end
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            // count saturates; bytes past the limit are dropped
            if (byte_count < MAX_BYTES) begin
               if (byte_count < HDR_SPAN)
                  seen_bytes[byte_count] = req_ch.frame_byte;
               byte_count++;
            end
            if (req_ch.last_byte) begin
               expected_headers.push_back(decode_header());
               clear_frame();
            end
         end
         records_pending <= expected_headers.size();
      end
   end

endmodule

// ===== test/tb_top.sv =====
// Testbench top: drives frames into the header parser and reports the verdict.
`timescale 1ns / 100ps
module tb_top;
   import eip_pkg::*;

   typedef enum int {KIND_TCP, KIND_IPV4, KIND_ARP, KIND_LENGTH, KIND_OTHER,
                     KIND_NOISE} frame_kind_type;

   // Small capture limit so overlong frames stay short
   localparam int TB_MAX_BYTES = 96;
   localparam int BUF_BYTES    = TB_MAX_BYTES + 64;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   records_pending;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   hold_request  = 0;
   logic [7:0] frame_bytes [BUF_BYTES];

   eip_req_if req_ch();
   eip_rsp_if rsp_ch();

   eth_ipv4_tcp_header_parser #(.MAX_FRAME_BYTES(TB_MAX_BYTES)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   header_record_checker #(.MAX_BYTES(TB_MAX_BYTES)) u_record_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .records_pending (records_pending)
   );

   // Clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Run limit
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when asked for one
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // One item, with a random gap ahead of it
   task automatic drive_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = $urandom_range(1, 6);
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.frame_byte <= b;
      req_ch.last_byte  <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1)
         @(posedge clock);
   endtask

   task automatic drive_frame(input int len);
      int i;
      for (i = 0; i < len; i++)
         drive_byte(frame_bytes[i], i == len - 1);
      if (send_idle_pct > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   task automatic wait_for_records();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (records_pending != 0)
         @(negedge clock);
   endtask

   task automatic set_frame_byte(input int pos, input logic [7:0] val, input int len);
      if (pos < len)
         frame_bytes[pos] = val;
   endtask

   // Frame of the given kind; truncated frames stop somewhere inside the headers
   task automatic build_frame(input frame_kind_type kind, input int ihl, input bit all_ones,
                              input bit truncate, output int len);
      int need;
      int i;
      logic [15:0] etype;
      logic [3:0]  version;
      logic [7:0]  proto;
      need    = TYPE_START + 2;
      etype   = 16'($urandom_range(16'hffff));
      version = ($urandom_range(99) < 90) ? 4'h4 : 4'($urandom_range(15));
      proto   = (kind == KIND_TCP) ? PROTO_TCP : 8'($urandom_range(255));
      case (kind)
         KIND_TCP, KIND_IPV4: begin
            etype = TYPE_IPV4;
            need  = VERHL_START + ((ihl > 5) ? ihl * 4 : 20) + TCP_HDR_LEN;
         end
         KIND_ARP:    etype = $urandom_range(1) ? TYPE_ARP : TYPE_RARP;
         KIND_LENGTH: etype = 16'($urandom_range(TYPE_MIN - 1));
         KIND_NOISE:  need  = $urandom_range(1, 100);
         default:     etype = 16'($urandom_range(16'hffff));
      endcase
      len = truncate ? $urandom_range(1, need) : need + $urandom_range(0, 16);
      for (i = 0; i < len; i++)
         frame_bytes[i] = all_ones ? 8'hff : 8'($urandom_range(255));
      if (kind != KIND_NOISE) begin
         set_frame_byte(TYPE_START, etype[15:8], len);
         set_frame_byte(TYPE_START + 1, etype[7:0], len);
      end
      if (kind == KIND_TCP || kind == KIND_IPV4) begin
         set_frame_byte(VERHL_START, {version, 4'(ihl)}, len);
         set_frame_byte(TTL_START + 1, proto, len);
      end
   endtask

   // Mostly well-formed IPv4/TCP, the rest other types and noise
   task automatic build_random_frame(output int len);
      int pick;
      frame_kind_type kind;
      pick = $urandom_range(99);
      if (pick < 45)      kind = KIND_TCP;
      else if (pick < 57) kind = KIND_IPV4;
      else if (pick < 67) kind = KIND_ARP;
      else if (pick < 77) kind = KIND_LENGTH;
      else if (pick < 87) kind = KIND_OTHER;
      else                kind = KIND_NOISE;
      build_frame(kind, $urandom_range(15), 1'b0, $urandom_range(99) < 20, len);
   endtask

   // Frame running past the capture limit
   task automatic drive_overlong_frame();
      int len;
      int i;
      build_frame(KIND_TCP, $urandom_range(5, 15), 1'b0, 1'b0, len);
      for (i = len; i < BUF_BYTES; i++)
         frame_bytes[i] = 8'($urandom_range(255));
      drive_frame(TB_MAX_BYTES + $urandom_range(1, 40));
   endtask

   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input int min_bytes, input int min_frames);
      int phase_bytes;
      int phase_frames;
      int len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      phase_bytes   = 0;
      phase_frames  = 0;
      while (phase_bytes < min_bytes || phase_frames < min_frames) begin
         build_random_frame(len);
         drive_frame(len);
         phase_bytes += len;
         phase_frames++;
      end
      wait_for_records();
   endtask

   // Stimulus and verdict
   initial begin
      int len;
      int i;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.frame_byte = 8'h00;
      req_ch.last_byte  = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Short frames at the field extremes
      drive_byte(8'hff, 1'b1);
      for (i = 0; i < 13; i++)
         frame_bytes[i] = 8'h00;
      drive_frame(13);
      for (i = 0; i < 14; i++)
         frame_bytes[i] = 8'hff;
      frame_bytes[TYPE_START]     = TYPE_ARP[15:8];
      frame_bytes[TYPE_START + 1] = TYPE_ARP[7:0];
      drive_frame(14);

      // TCP with the smallest and largest IHL, all ones; plain IPv4; ARP; an overlong TCP frame
      build_frame(KIND_TCP, 0, 1'b1, 1'b0, len);
      drive_frame(len);
      build_frame(KIND_TCP, 15, 1'b1, 1'b0, len);
      drive_frame(len);
      build_frame(KIND_IPV4, 5, 1'b0, 1'b0, len);
      drive_frame(len);
      build_frame(KIND_ARP, 5, 1'b0, 1'b0, len);
      drive_frame(len);
      drive_overlong_frame();
      wait_for_records();

      // Random traffic under different idle and stall patterns
      run_traffic_phase(0, 0, 150, 4);
      run_traffic_phase(76, 0, 150, 4);
      drive_overlong_frame();
      run_traffic_phase(0, 76, 150, 4);
      run_traffic_phase(22, 22, 150, 4);

      // Long receiver hold-off while short frames keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 400;
      repeat (8) begin
         build_frame(KIND_LENGTH, 5, 1'b0, 1'b1, len);
         drive_frame(len);
      end
      wait_for_records();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
